// ----- rtl/ubxr_pkg.sv -----
// Package: shared types, codes and constants of the UBX frame receiver.
`default_nettype none
package ubxr_pkg;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned LEN_W    = 16;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned ACK_W    = 2;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 16;

   localparam logic [LEN_W-1:0]  MAX_PAYLOAD_RESET = 16'd1024;
   localparam logic [BYTE_W-1:0] EXP_CLASS_RESET   = 8'h00;
   localparam logic [BYTE_W-1:0] EXP_ID_RESET      = 8'h00;

   localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'hB5;
   localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'h62;
   localparam logic [BYTE_W-1:0] ACK_CLASS   = 8'h05;
   localparam logic [BYTE_W-1:0] ACK_ID_ACK  = 8'h01;
   localparam logic [BYTE_W-1:0] ACK_ID_NAK  = 8'h00;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_PAYLOAD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EXP_CLASS   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_EXP_ID      = 2'd2;

   localparam logic KIND_PAYLOAD   = 1'b0;
   localparam logic KIND_FRAME_END = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_CKSUM    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_OVER_LIM = 2'd2;

   localparam logic [ACK_W-1:0] ACK_NONE = 2'd0;
   localparam logic [ACK_W-1:0] ACK_ACK  = 2'd1;
   localparam logic [ACK_W-1:0] ACK_NAK  = 2'd2;

   typedef struct packed {
      logic [LEN_W-1:0]  max_payload;
      logic [BYTE_W-1:0] expected_class;
      logic [BYTE_W-1:0] expected_id;
   } cfg_type;

   typedef struct packed {
      logic                kind;
      logic [BYTE_W-1:0]   payload_byte;
      logic [LEN_W-1:0]    byte_offset;
      logic [BYTE_W-1:0]   msg_class;
      logic [BYTE_W-1:0]   msg_id;
      logic [LEN_W-1:0]    payload_length;
      logic [STATUS_W-1:0] status;
      logic [ACK_W-1:0]    ack_result;
      logic                last;
   } rsp_type;

endpackage : ubxr_pkg
`default_nettype wire

// ----- rtl/ubx_frame_receiver.sv -----
// UBX frame receiver top level: input word register, parser, result register.
// A word waits in the input word register; its result, if any, goes to the result
// register when the parser steps and is offered on rsp_ from then on; words that
// give no result: sync, class, id, length low, checksum A, length high within limit.
// Throughput: one word per cycle, held off while a result waits undrained on rsp_.
// Reset: synchronous, active high; clears the word and result valid flags, the
// parser state (sync hunt) and sets the registers to their defaults.
`default_nettype none
module ubx_frame_receiver
   import ubxr_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // byte stream in
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [BYTE_W-1:0]     req_rx_byte,
   // results out
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic                       rsp_kind,
   output logic [BYTE_W-1:0]          rsp_payload_byte,
   output logic [LEN_W-1:0]           rsp_byte_offset,
   output logic [BYTE_W-1:0]          rsp_msg_class,
   output logic [BYTE_W-1:0]          rsp_msg_id,
   output logic [LEN_W-1:0]           rsp_payload_length,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic [ACK_W-1:0]           rsp_ack_result,
   output logic                       rsp_last,
   // register writes
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   cfg_type cfg;

   // input word register
   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff;

   // result register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff;

   logic    step;
   logic    result_valid;
   rsp_type result;

   // Advance the parser when a word is held and the result register is free or
   // being drained this cycle; every step may produce a result, so wait for room.
   assign step      = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || step;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_ready) in_valid_in = req_valid;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (step) rsp_valid_in = result_valid;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers: load on accept, hold otherwise
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) in_byte_ff <= req_rx_byte;
      if (step && result_valid) rsp_ff <= result;
   end

   ubxr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   ubxr_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .rx_byte      (in_byte_ff),
      .cfg          (cfg),
      .result_valid (result_valid),
      .result       (result)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = rsp_ff.kind;
   assign rsp_payload_byte   = rsp_ff.payload_byte;
   assign rsp_byte_offset    = rsp_ff.byte_offset;
   assign rsp_msg_class      = rsp_ff.msg_class;
   assign rsp_msg_id         = rsp_ff.msg_id;
   assign rsp_payload_length = rsp_ff.payload_length;
   assign rsp_status         = rsp_ff.status;
   assign rsp_ack_result     = rsp_ff.ack_result;
   assign rsp_last           = rsp_ff.last;

endmodule : ubx_frame_receiver
`default_nettype wire

// ----- rtl/ubxr_csr.sv -----
// Configuration registers of the UBX frame receiver.
`default_nettype none
module ubxr_csr
   import ubxr_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data,
   output cfg_type                    cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_MAX_PAYLOAD: cfg_in.max_payload    = csr_data;
            CSR_EXP_CLASS:   cfg_in.expected_class = csr_data[BYTE_W-1:0];
            CSR_EXP_ID:      cfg_in.expected_id    = csr_data[BYTE_W-1:0];
            default:         cfg_in = cfg_ff;  // drop writes beyond the list
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_payload    <= MAX_PAYLOAD_RESET;
         cfg_ff.expected_class <= EXP_CLASS_RESET;
         cfg_ff.expected_id    <= EXP_ID_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule : ubxr_csr
`default_nettype wire

// ----- rtl/ubxr_parser.sv -----
// Frame state machine: sync hunt, header capture, Fletcher sums and reports.
`default_nettype none
module ubxr_parser
   import ubxr_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step,
   input  wire logic [BYTE_W-1:0] rx_byte,
   input  wire cfg_type           cfg,
   output logic                   result_valid,
   output rsp_type                result
);

   localparam logic [3:0] PH_SYNC1 = 4'd0;
   localparam logic [3:0] PH_SYNC2 = 4'd1;
   localparam logic [3:0] PH_CLASS = 4'd2;
   localparam logic [3:0] PH_ID    = 4'd3;
   localparam logic [3:0] PH_LENLO = 4'd4;
   localparam logic [3:0] PH_LENHI = 4'd5;
   localparam logic [3:0] PH_PAYLD = 4'd6;
   localparam logic [3:0] PH_CKA   = 4'd7;
   localparam logic [3:0] PH_CKB   = 4'd8;

   logic [3:0]        phase_ff, phase_in;
   logic [BYTE_W-1:0] class_ff, class_in;
   logic [BYTE_W-1:0] id_ff, id_in;
   logic [LEN_W-1:0]  length_ff, length_in;
   logic [LEN_W-1:0]  count_ff, count_in;
   logic [BYTE_W-1:0] sum_a_ff, sum_a_in;
   logic [BYTE_W-1:0] sum_b_ff, sum_b_in;
   logic [BYTE_W-1:0] rx_sum_a_ff, rx_sum_a_in;
   logic [BYTE_W-1:0] echo_class_ff, echo_class_in;
   logic [BYTE_W-1:0] echo_id_ff, echo_id_in;

   logic [BYTE_W-1:0] base_a, base_b, add_a, add_b;
   logic [LEN_W-1:0]  count_inc;
   logic [LEN_W-1:0]  new_length;
   logic              cksum_ok;

   // the class byte restarts both sums
   assign base_a     = (phase_ff == PH_CLASS) ? '0 : sum_a_ff;
   assign base_b     = (phase_ff == PH_CLASS) ? '0 : sum_b_ff;
   assign add_a      = base_a + rx_byte;
   assign add_b      = base_b + add_a;
   assign count_inc  = count_ff + 1'b1;
   assign new_length = {rx_byte, length_ff[BYTE_W-1:0]};
   assign cksum_ok   = (rx_sum_a_ff == sum_a_ff) && (rx_byte == sum_b_ff);

   always_comb begin
      phase_in      = phase_ff;
      class_in      = class_ff;
      id_in         = id_ff;
      length_in     = length_ff;
      count_in      = count_ff;
      sum_a_in      = sum_a_ff;
      sum_b_in      = sum_b_ff;
      rx_sum_a_in   = rx_sum_a_ff;
      echo_class_in = echo_class_ff;
      echo_id_in    = echo_id_ff;

      result_valid          = 1'b0;
      result.kind           = KIND_PAYLOAD;
      result.payload_byte   = '0;
      result.byte_offset    = '0;
      result.msg_class      = class_ff;
      result.msg_id         = id_ff;
      result.payload_length = length_ff;
      result.status         = STATUS_OK;
      result.ack_result     = ACK_NONE;
      result.last           = 1'b0;

      unique case (phase_ff)
         PH_SYNC1: begin
            if (rx_byte == SYNC_FIRST) phase_in = PH_SYNC2;
         end
         PH_SYNC2: begin
            if (rx_byte == SYNC_SECOND) phase_in = PH_CLASS;
            else if (rx_byte != SYNC_FIRST) phase_in = PH_SYNC1;
         end
         PH_CLASS: begin
            echo_class_in = '0;
            echo_id_in    = '0;
            class_in      = rx_byte;
            sum_a_in      = add_a;
            sum_b_in      = add_b;
            phase_in      = PH_ID;
         end
         PH_ID: begin
            id_in    = rx_byte;
            sum_a_in = add_a;
            sum_b_in = add_b;
            phase_in = PH_LENLO;
         end
         PH_LENLO: begin
            length_in = {{(LEN_W-BYTE_W){1'b0}}, rx_byte};
            sum_a_in  = add_a;
            sum_b_in  = add_b;
            phase_in  = PH_LENHI;
         end
         PH_LENHI: begin
            length_in = new_length;
            sum_a_in  = add_a;
            sum_b_in  = add_b;
            count_in  = '0;
            if (new_length > cfg.max_payload) begin
               result_valid          = 1'b1;
               result.kind           = KIND_FRAME_END;
               result.payload_length = new_length;
               result.status         = STATUS_OVER_LIM;
               result.last           = 1'b1;
               phase_in              = PH_SYNC1;
            end else if (new_length == '0) begin
               phase_in = PH_CKA;
            end else begin
               phase_in = PH_PAYLD;
            end
         end
         PH_PAYLD: begin
            if (count_ff == LEN_W'(0)) echo_class_in = rx_byte;
            else if (count_ff == LEN_W'(1)) echo_id_in = rx_byte;
            sum_a_in            = add_a;
            sum_b_in            = add_b;
            result_valid        = 1'b1;
            result.payload_byte = rx_byte;
            result.byte_offset  = count_ff;
            count_in            = count_inc;
            if (count_inc >= length_ff) phase_in = PH_CKA;
         end
         PH_CKA: begin
            rx_sum_a_in = rx_byte;
            phase_in    = PH_CKB;
         end
         PH_CKB: begin
            result_valid  = 1'b1;
            result.kind   = KIND_FRAME_END;
            result.status = cksum_ok ? STATUS_OK : STATUS_CKSUM;
            result.last   = 1'b1;
            if (cksum_ok && (class_ff == ACK_CLASS) && (length_ff >= LEN_W'(2)) &&
                (echo_class_ff == cfg.expected_class) &&
                (echo_id_ff == cfg.expected_id)) begin
               if (id_ff == ACK_ID_ACK) result.ack_result = ACK_ACK;
               else if (id_ff == ACK_ID_NAK) result.ack_result = ACK_NAK;
            end
            phase_in = PH_SYNC1;
         end
         default: begin
            phase_in = PH_SYNC1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_SYNC1;
         class_ff      <= '0;
         id_ff         <= '0;
         length_ff     <= '0;
         count_ff      <= '0;
         sum_a_ff      <= '0;
         sum_b_ff      <= '0;
         rx_sum_a_ff   <= '0;
         echo_class_ff <= '0;
         echo_id_ff    <= '0;
      end else if (step) begin
         phase_ff      <= phase_in;
         class_ff      <= class_in;
         id_ff         <= id_in;
         length_ff     <= length_in;
         count_ff      <= count_in;
         sum_a_ff      <= sum_a_in;
         sum_b_ff      <= sum_b_in;
         rx_sum_a_ff   <= rx_sum_a_in;
         echo_class_ff <= echo_class_in;
         echo_id_ff    <= echo_id_in;
      end
   end

endmodule : ubxr_parser
`default_nettype wire
